@@ hdl/iff_pkg.sv @@
`timescale 1ns / 1ps
package iff_pkg;

    localparam int DREG_W = 80;
    localparam int BCD_DIGITS = 20;
    localparam int OCT_DIGITS = 22;
    localparam int HEX_DIGITS = 16;
    localparam int BIN_DIGITS = 64;
    localparam int RAW_W = 64;

    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_OCT  = 3'd2;
    localparam logic [2:0] OP_HEXL = 3'd3;
    localparam logic [2:0] OP_HEXU = 3'd4;
    localparam logic [2:0] OP_BIN  = 3'd5;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;

    typedef enum logic [1:0] {
        RAD_DEC,
        RAD_OCT,
        RAD_HEX,
        RAD_BIN
    } radix_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_PREP,
        ST_EMIT
    } state_t;

endpackage

@@ hdl/iff_in_if.sv @@
`timescale 1ns / 1ps
interface iff_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [63:0] value;
    logic        wide;
    logic [7:0]  width;
    logic [7:0]  precision;
    logic        left_justify;
    logic        force_sign;
    logic        space_sign;
    logic        zero_fill;
    logic        alternate;

    modport source (
        output valid, op, value, wide, width, precision, left_justify,
        output force_sign, space_sign, zero_fill, alternate,
        input  ready
    );
    modport sink (
        input  valid, op, value, wide, width, precision, left_justify,
        input  force_sign, space_sign, zero_fill, alternate,
        output ready
    );
endinterface

@@ hdl/iff_out_if.sv @@
`timescale 1ns / 1ps
interface iff_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] chars;
    logic [3:0]  char_count;
    logic        last;
    logic [8:0]  field_length;

    modport source (
        output valid, chars, char_count, last, field_length,
        input  ready
    );
    modport sink (
        input  valid, chars, char_count, last, field_length,
        output ready
    );
endinterface

@@ hdl/iff_dabble.sv @@
`timescale 1ns / 1ps
module iff_dabble
    import iff_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RAW_W-1:0]    bin,
    output logic                busy,
    output logic [DREG_W-1:0]   bcd
);

    logic [RAW_W-1:0]  bin_reg, bin_next;
    logic [DREG_W-1:0] bcd_reg, bcd_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic [DREG_W-1:0] adj;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                          : bcd_reg[i*4 +: 4];
        end
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            bin_next = bin;
            bcd_next = '0;
            cnt_next = 7'(RAW_W);
        end
        else if (cnt_reg != '0)
        begin
            bcd_next = {adj[DREG_W-2:0], bin_reg[RAW_W-1]};
            bin_next = {bin_reg[RAW_W-2:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign busy = (cnt_reg != '0);
    assign bcd  = bcd_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 7'(RAW_W)) else $error("dabble count out of range");
    a_start_load: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> cnt_reg == 7'(RAW_W)) else $error("dabble start not loaded");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !start) |=> cnt_reg == $past(cnt_reg) - 7'd1)
        else $error("dabble count skipped");

endmodule

@@ hdl/integer_field_formatter.sv @@
`timescale 1ns / 1ps
// decimal values first pass through the iff_dabble binary-to-bcd converter, then leading
// zero digits are stripped (up to 63), the field bounds are computed, and the characters
// are emitted one per cycle while the output is not stalled, packed into beats of up to 8;
// a new transaction is accepted once the last beat of the previous field has been formed
// asynchronous active-low reset returns to idle with no beat pending
module integer_field_formatter
    import iff_pkg::*;
#(
    parameter int MAX_WIDTH  = 255,
    parameter int VALUE_BITS = 64
)
(
    input  logic clk,
    input  logic rst_n,
    iff_in_if.sink    in_item,
    iff_out_if.source out_beat
);

    localparam logic [RAW_W-1:0] VMASK = {RAW_W{1'b1}} >> (RAW_W - VALUE_BITS);
    localparam logic [RAW_W-1:0] NMASK = 64'h0000_0000_ffff_ffff;

    state_t state_reg, state_next;

    radix_t            rad_reg, rad_next, rad_in;
    logic              upper_reg, upper_next;
    logic [1:0]        plen_reg, plen_next, plen_in;
    logic [7:0]        pre0_reg, pre0_next, pre0_in;
    logic [7:0]        pre1_reg, pre1_next, pre1_in;
    logic              lj_reg, lj_next;
    logic              zf_reg, zf_next;
    logic [7:0]        wid_reg, wid_next, wid_in;
    logic [7:0]        prec_reg, prec_next, prec_in;
    logic [DREG_W-1:0] dreg_reg, dreg_next;
    logic [6:0]        nd_reg, nd_next;
    logic [8:0]        b1_reg, b1_next, b2_reg, b2_next, b3_reg, b3_next;
    logic [8:0]        b4_reg, b4_next, flen_reg, flen_next;
    logic [8:0]        pos_reg, pos_next;
    logic [63:0]       acc_reg, acc_next;
    logic [3:0]        cnt_reg, cnt_next;

    logic              ov_reg, ov_next;
    logic [63:0]       oc_reg, oc_next;
    logic [3:0]        on_reg, on_next;
    logic              ol_reg, ol_next;
    logic [8:0]        of_reg, of_next;

    logic [RAW_W-1:0]  v_in, mag_in;
    logic              neg_in, accept, dab_busy, dab_start;
    logic [DREG_W-1:0] dab_bcd;
    logic [3:0]        top_dig;
    logic [7:0]        dig_ch, ch;
    logic [8:0]        ndig, ndig0, tn, pad, b1c, b2c, b3c, wid9;
    logic              in_digits, beat_done, advance;

    iff_dabble u_dabble (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dab_start),
        .bin   (mag_in),
        .busy  (dab_busy),
        .bcd   (dab_bcd)
    );

    assign in_item.ready = (state_reg == ST_IDLE);
    assign accept = in_item.valid && in_item.ready;

    always_comb
    begin
        v_in   = in_item.wide ? (in_item.value & VMASK) : (in_item.value & NMASK);
        neg_in = (in_item.op == OP_SDEC) &&
                 (in_item.wide ? v_in[VALUE_BITS-1] : v_in[31]);
        mag_in = neg_in ? ((~v_in + 64'd1) & (in_item.wide ? VMASK : NMASK)) : v_in;
        wid_in  = ({2'b0, in_item.width} > 10'(MAX_WIDTH)) ? 8'(MAX_WIDTH)
                                                          : in_item.width;
        prec_in = ({2'b0, in_item.precision} > 10'(MAX_WIDTH)) ? 8'(MAX_WIDTH)
                                                              : in_item.precision;
        rad_in  = RAD_DEC;
        plen_in = 2'd0;
        pre0_in = CH_ZERO;
        pre1_in = CH_LX;
        case (in_item.op)
            OP_SDEC:
            begin
                plen_in = (neg_in || in_item.force_sign || in_item.space_sign) ? 2'd1 : 2'd0;
                pre0_in = neg_in ? CH_MINUS : (in_item.force_sign ? CH_PLUS : CH_SPACE);
            end
            OP_OCT:
            begin
                rad_in  = RAD_OCT;
                plen_in = in_item.alternate ? 2'd1 : 2'd0;
            end
            OP_HEXL:
            begin
                rad_in  = RAD_HEX;
                plen_in = in_item.alternate ? 2'd2 : 2'd0;
            end
            OP_HEXU:
            begin
                rad_in  = RAD_HEX;
                plen_in = in_item.alternate ? 2'd2 : 2'd0;
                pre1_in = CH_UX;
            end
            OP_BIN:
            begin
                rad_in  = RAD_BIN;
                plen_in = in_item.alternate ? 2'd2 : 2'd0;
                pre1_in = CH_LB;
            end
            default:
            begin
                rad_in = RAD_DEC;
            end
        endcase
    end

    assign dab_start = accept && (rad_in == RAD_DEC);

    always_comb
    begin
        case (rad_reg)
            RAD_OCT: top_dig = {1'b0, dreg_reg[DREG_W-1 -: 3]};
            RAD_BIN: top_dig = {3'b0, dreg_reg[DREG_W-1]};
            default: top_dig = dreg_reg[DREG_W-1 -: 4];
        endcase
        dig_ch = (top_dig < 4'd10) ? CH_ZERO + {4'b0, top_dig}
                                   : (upper_reg ? CH_UA : CH_LA) + {4'b0, top_dig} - 8'd10;

        wid9  = {1'b0, wid_reg};
        ndig0 = ({2'b0, nd_reg} > {1'b0, prec_reg}) ? {2'b0, nd_reg} : {1'b0, prec_reg};
        ndig  = (zf_reg && (wid9 > ndig0 + {7'b0, plen_reg})) ? wid9 - {7'b0, plen_reg}
                                                               : ndig0;
        tn    = ndig + {7'b0, plen_reg};
        pad   = (wid9 > tn) ? wid9 - tn : 9'd0;
        b1c   = lj_reg ? 9'd0 : pad;
        b2c   = b1c + {7'b0, plen_reg};
        b3c   = b2c + ndig - {2'b0, nd_reg};

        in_digits = 1'b0;
        if (pos_reg < b1_reg)
        begin
            ch = CH_SPACE;
        end
        else if (pos_reg < b2_reg)
        begin
            ch = (pos_reg == b1_reg) ? pre0_reg : pre1_reg;
        end
        else if (pos_reg < b3_reg)
        begin
            ch = CH_ZERO;
        end
        else if (pos_reg < b4_reg)
        begin
            ch = dig_ch;
            in_digits = 1'b1;
        end
        else
        begin
            ch = CH_SPACE;
        end
        beat_done = (cnt_reg == 4'd7) || (pos_reg == flen_reg - 9'd1);
        advance   = !(beat_done && ov_reg && !out_beat.ready);
    end

    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        upper_next = upper_reg;
        plen_next  = plen_reg;
        pre0_next  = pre0_reg;
        pre1_next  = pre1_reg;
        lj_next    = lj_reg;
        zf_next    = zf_reg;
        wid_next   = wid_reg;
        prec_next  = prec_reg;
        dreg_next  = dreg_reg;
        nd_next    = nd_reg;
        b1_next    = b1_reg;
        b2_next    = b2_reg;
        b3_next    = b3_reg;
        b4_next    = b4_reg;
        flen_next  = flen_reg;
        pos_next   = pos_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && !out_beat.ready;
        oc_next    = oc_reg;
        on_next    = on_reg;
        ol_next    = ol_reg;
        of_next    = of_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rad_next   = rad_in;
                    upper_next = (in_item.op == OP_HEXU);
                    plen_next  = plen_in;
                    pre0_next  = pre0_in;
                    pre1_next  = pre1_in;
                    lj_next    = in_item.left_justify;
                    zf_next    = in_item.zero_fill;
                    wid_next   = wid_in;
                    prec_next  = prec_in;
                    case (rad_in)
                        RAD_OCT:
                        begin
                            dreg_next = {2'b0, mag_in, 14'b0};
                            nd_next   = 7'(OCT_DIGITS);
                        end
                        RAD_HEX:
                        begin
                            dreg_next = {mag_in, 16'b0};
                            nd_next   = 7'(HEX_DIGITS);
                        end
                        RAD_BIN:
                        begin
                            dreg_next = {mag_in, 16'b0};
                            nd_next   = 7'(BIN_DIGITS);
                        end
                        default:
                        begin
                            nd_next = 7'(BCD_DIGITS);
                        end
                    endcase
                    state_next = (rad_in == RAD_DEC) ? ST_CONV : ST_NORM;
                end
            end
            ST_CONV:
            begin
                if (!dab_busy)
                begin
                    dreg_next  = dab_bcd;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (top_dig == 4'd0 && nd_reg > 7'd1)
                begin
                    nd_next = nd_reg - 7'd1;
                    case (rad_reg)
                        RAD_OCT: dreg_next = {dreg_reg[DREG_W-4:0], 3'b0};
                        RAD_BIN: dreg_next = {dreg_reg[DREG_W-2:0], 1'b0};
                        default: dreg_next = {dreg_reg[DREG_W-5:0], 4'b0};
                    endcase
                end
                else
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                b1_next    = b1c;
                b2_next    = b2c;
                b3_next    = b3c;
                b4_next    = b3c + {2'b0, nd_reg};
                flen_next  = tn + pad;
                pos_next   = '0;
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (advance)
                begin
                    acc_next = acc_reg;
                    acc_next[cnt_reg[2:0]*8 +: 8] = ch;
                    if (in_digits)
                    begin
                        case (rad_reg)
                            RAD_OCT: dreg_next = {dreg_reg[DREG_W-4:0], 3'b0};
                            RAD_BIN: dreg_next = {dreg_reg[DREG_W-2:0], 1'b0};
                            default: dreg_next = {dreg_reg[DREG_W-5:0], 4'b0};
                        endcase
                    end
                    pos_next = pos_reg + 9'd1;
                    cnt_next = cnt_reg + 4'd1;
                    if (beat_done)
                    begin
                        ov_next  = 1'b1;
                        oc_next  = acc_next;
                        on_next  = cnt_reg + 4'd1;
                        ol_next  = (pos_reg == flen_reg - 9'd1);
                        of_next  = flen_reg;
                        acc_next = '0;
                        cnt_next = '0;
                        if (pos_reg == flen_reg - 9'd1)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg   <= rad_next;
        upper_reg <= upper_next;
        plen_reg  <= plen_next;
        pre0_reg  <= pre0_next;
        pre1_reg  <= pre1_next;
        lj_reg    <= lj_next;
        zf_reg    <= zf_next;
        wid_reg   <= wid_next;
        prec_reg  <= prec_next;
        dreg_reg  <= dreg_next;
        nd_reg    <= nd_next;
        b1_reg    <= b1_next;
        b2_reg    <= b2_next;
        b3_reg    <= b3_next;
        b4_reg    <= b4_next;
        flen_reg  <= flen_next;
        pos_reg   <= pos_next;
        acc_reg   <= acc_next;
        cnt_reg   <= cnt_next;
        oc_reg    <= oc_next;
        on_reg    <= on_next;
        ol_reg    <= ol_next;
        of_reg    <= of_next;
    end

    assign out_beat.valid        = ov_reg;
    assign out_beat.chars        = oc_reg;
    assign out_beat.char_count   = on_reg;
    assign out_beat.last         = ol_reg;
    assign out_beat.field_length = of_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> (on_reg >= 4'd1 && on_reg <= 4'd8))
        else $error("beat count out of range");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT |-> pos_reg < flen_reg)
        else $error("character position past field end");
    a_nd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_NORM |-> nd_reg != 7'd0)
        else $error("digit count reached zero");
    a_beat_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !ol_reg) |-> on_reg == 4'd8)
        else $error("short beat before last");

endmodule

@@ tb/integer_field_formatter_tb.sv @@
`timescale 1ns / 1ps
module integer_field_formatter_tb;
    import iff_pkg::*;

    typedef struct packed {
        logic [63:0] chars;
        logic [3:0]  char_count;
        logic        last;
        logic [8:0]  field_length;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    iff_in_if  in_item();
    iff_out_if out_beat();

    integer_field_formatter u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_item(in_item),
        .out_beat(out_beat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    beat_t beat_q[$];
    int    errors = 0;
    int    idle_cycles = 0;
    bit    hold_off = 1'b0;
    bit    done = 1'b0;

    function automatic void format_field(
        input logic [2:0] op, input logic [63:0] value, input logic wide,
        input logic [7:0] width, input logic [7:0] precision,
        input logic lj, input logic fs, input logic ss, input logic zf,
        input logic alt);
        logic [7:0]  text[$];
        logic [7:0]  digs[$];
        logic [7:0]  pre[$];
        logic [63:0] v;
        logic [63:0] radix;
        logic [63:0] d;
        bit          upper;
        int          ndig;
        int          pad;
        int          flen;
        beat_t       b;
        upper = 1'b0;
        radix = 10;
        v = wide ? value : {32'd0, value[31:0]};
        if (op == OP_SDEC)
        begin
            if (wide ? v[63] : v[31])
            begin
                v = wide ? (~v + 64'd1) : {32'd0, ~v[31:0] + 32'd1};
                pre.push_back(CH_MINUS);
            end
            else if (fs)
                pre.push_back(CH_PLUS);
            else if (ss)
                pre.push_back(CH_SPACE);
        end
        else
        begin
            case (op)
                OP_OCT:
                begin
                    radix = 8;
                    if (alt) pre.push_back(CH_ZERO);
                end
                OP_HEXL:
                begin
                    radix = 16;
                    if (alt) begin pre.push_back(CH_ZERO); pre.push_back(CH_LX); end
                end
                OP_HEXU:
                begin
                    radix = 16;
                    upper = 1'b1;
                    if (alt) begin pre.push_back(CH_ZERO); pre.push_back(CH_UX); end
                end
                OP_BIN:
                begin
                    radix = 2;
                    if (alt) begin pre.push_back(CH_ZERO); pre.push_back(CH_LB); end
                end
                default: radix = 10;
            endcase
        end
        do
        begin
            d = v % radix;
            v = v / radix;
            if (d < 10)
                digs.push_front(CH_ZERO + 8'(d));
            else
                digs.push_front((upper ? CH_UA : CH_LA) + 8'(d - 10));
        end while (v != 0);
        ndig = digs.size();
        if (precision > ndig) ndig = precision;
        if (zf && width > ndig + pre.size()) ndig = width - pre.size();
        pad = (width > ndig + pre.size()) ? width - ndig - pre.size() : 0;
        if (!lj) repeat (pad) text.push_back(CH_SPACE);
        foreach (pre[i]) text.push_back(pre[i]);
        repeat (ndig - digs.size()) text.push_back(CH_ZERO);
        foreach (digs[i]) text.push_back(digs[i]);
        if (lj) repeat (pad) text.push_back(CH_SPACE);
        flen = text.size();
        for (int k = 0; k < flen; k += 8)
        begin
            b = '0;
            b.char_count = 4'((flen - k > 8) ? 8 : flen - k);
            for (int j = 0; j < b.char_count; j++)
                b.chars[8*j +: 8] = text[k + j];
            b.last = (k + 8 >= flen);
            b.field_length = 9'(flen);
            beat_q.push_back(b);
        end
    endfunction

    task automatic send_item(
        input logic [2:0] op, input logic [63:0] value, input logic wide,
        input logic [7:0] width, input logic [7:0] precision,
        input logic lj, input logic fs, input logic ss, input logic zf,
        input logic alt);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap + 1) @(posedge clk);
        in_item.valid        <= 1'b1;
        in_item.op           <= op;
        in_item.value        <= value;
        in_item.wide         <= wide;
        in_item.width        <= width;
        in_item.precision    <= precision;
        in_item.left_justify <= lj;
        in_item.force_sign   <= fs;
        in_item.space_sign   <= ss;
        in_item.zero_fill    <= zf;
        in_item.alternate    <= alt;
        do @(posedge clk); while (!in_item.ready);
        format_field(op, value, wide, width, precision, lj, fs, ss, zf, alt);
        in_item.valid <= 1'b0;
    endtask

    task automatic send_random(input bit big);
        logic [63:0] v;
        case ($urandom_range(0, 4))
            0: v = 64'(1) << $urandom_range(0, 63);
            1: v = {$urandom, $urandom};
            2: v = $urandom_range(0, 20);
            3: v = -64'($urandom_range(1, 20));
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        send_item(3'($urandom_range(0, 7)), v, 1'($urandom),
                  big ? 8'($urandom) : 8'($urandom_range(0, 24)),
                  big ? 8'($urandom) : 8'($urandom_range(0, 24)),
                  1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                  1'($urandom));
    endtask

    task automatic test_extremes();
        send_item(OP_SDEC, 64'h8000_0000_0000_0000, 1, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_SDEC, 64'h0000_0000_8000_0000, 0, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_UDEC, '1, 1, 0, 0, 0, 0, 0, 0, 0);
        send_item(OP_BIN, '1, 1, 255, 255, 0, 0, 0, 0, 1);
        send_item(OP_SDEC, 0, 0, 255, 0, 1, 1, 1, 1, 1);
        send_item(OP_HEXU, 64'hFFFF_FFFF_DEAD_BEEF, 0, 0, 255, 1, 0, 0, 0, 1);
    endtask

    task automatic test_modes();
        for (int op = 0; op < 8; op++)
        begin
            send_item(3'(op), 64'h0123_4567_89AB_CDEF, 1, 20, 0, 0, 0, 0, 0, 1);
            send_item(3'(op), 0, 0, 6, 3, 1, 1, 1, 0, 1);
        end
    endtask

    task automatic test_flags();
        send_item(OP_SDEC, 42, 0, 8, 0, 0, 1, 1, 0, 0);
        send_item(OP_SDEC, 42, 0, 8, 0, 1, 0, 1, 0, 0);
        send_item(OP_SDEC, -64'd42, 1, 10, 4, 1, 0, 0, 1, 0);
        send_item(OP_UDEC, 42, 0, 10, 4, 1, 1, 1, 0, 1);
        send_item(OP_OCT, 8, 0, 10, 5, 0, 0, 0, 1, 1);
        send_item(OP_HEXL, 255, 0, 3, 0, 1, 0, 0, 1, 1);
    endtask

    task automatic test_random();
        for (int i = 0; i < 220; i++)
            send_random($urandom_range(0, 19) == 0);
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            send_random(0);
        wait (!hold_off);
    endtask

    initial
    begin
        in_item.valid        = 1'b0;
        in_item.op           = OP_SDEC;
        in_item.value        = '0;
        in_item.wide         = 1'b0;
        in_item.width        = '0;
        in_item.precision    = '0;
        in_item.left_justify = 1'b0;
        in_item.force_sign   = 1'b0;
        in_item.space_sign   = 1'b0;
        in_item.zero_fill    = 1'b0;
        in_item.alternate    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_modes();
        test_flags();
        test_backpressure();
        test_random();
        wait (beat_q.size() == 0);
        repeat (400) @(posedge clk);
        done = 1'b1;
    end

    // output ready: random stalls, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_beat.ready <= 1'b0;
        else if (hold_off)
            out_beat.ready <= 1'b0;
        else if ($urandom_range(0, 19) == 0)
            out_beat.ready <= 1'b0;
        else
            out_beat.ready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end

    initial
    begin
        wait (hold_off);
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
    end

    // check each transaction against the oldest expected beat
    always @(posedge clk)
    begin
        if (rst_n && out_beat.valid && out_beat.ready)
        begin
            if (beat_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat chars=%h", $time, out_beat.chars);
            end
            else
            begin
                beat_t e;
                e = beat_q.pop_front();
                if (out_beat.chars !== e.chars)
                begin
                    errors++;
                    $display("%0t: chars exp %h got %h", $time, e.chars, out_beat.chars);
                end
                if (out_beat.char_count !== e.char_count)
                begin
                    errors++;
                    $display("%0t: char_count exp %0d got %0d", $time, e.char_count,
                             out_beat.char_count);
                end
                if (out_beat.last !== e.last)
                begin
                    errors++;
                    $display("%0t: last exp %0d got %0d", $time, e.last, out_beat.last);
                end
                if (out_beat.field_length !== e.field_length)
                begin
                    errors++;
                    $display("%0t: field_length exp %0d got %0d", $time, e.field_length,
                             out_beat.field_length);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_item.valid && in_item.ready) || (out_beat.valid && out_beat.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (done || idle_cycles >= 20000);
        if (!done)
        begin
            $display("%0t: timeout, %0d beats outstanding", $time, beat_q.size());
            $display("FAIL");
        end
        else if (errors == 0 && beat_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
